// ===== hw/rtl/indexed_ordered_list_engine_assert.svh =====
// Assertion macros shared by the checker of the indexed ordered list engine.
`ifndef INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IOLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/iole_pkg.sv =====
// Package with the types and constants of the indexed ordered list engine.
`timescale 1ns / 1ps
`default_nettype none
package iole_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WIDTH_DEF = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic put_value;
        logic finish;
        logic cnt_inc;
        logic cnt_dec;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       ok;
        logic       need_shift;
        logic       ptr_last;
    } t_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/iole_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module iole_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/iole_datapath.sv =====
// Datapath of the list engine: request registers, entry store, shift pointer and result word.
`timescale 1ns / 1ps
`default_nettype none
module iole_datapath #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire iole_pkg::t_cmd               i_cmd,
    output iole_pkg::t_stat                   o_stat,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_position,
    input  wire logic [WIDTH-1:0]             i_value,
    output logic                              o_valid,
    output logic      [1:0]                   o_status,
    output logic      [WIDTH-1:0]             o_read_value,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);
    import iole_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]       r_kind;
    logic [CW-1:0]    r_pos;
    logic [WIDTH-1:0] r_value;
    logic [1:0]       r_status;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_ptr;
    logic             r_prev_vld;
    logic [AW-1:0]    r_prev_addr;
    logic             r_valid;
    logic [1:0]       r_out_status;
    logic [WIDTH-1:0] r_out_word;
    logic [CW-1:0]    r_out_count;

    logic [1:0]       n_status;
    logic [AW-1:0]    n_ptr;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    w_cnt_m1;
    logic [CW-1:0]    w_in_pos_p1;
    logic [CW-1:0]    w_pos_p1;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [WIDTH-1:0] w_wdata;
    logic [WIDTH-1:0] w_rdata;

    assign w_cnt_m1    = r_count - CW'(1);
    assign w_in_pos_p1 = i_position + CW'(1);
    assign w_pos_p1    = r_pos + CW'(1);

    always_comb begin
        case (i_kind)
            KIND_INSERT: begin
                if (i_position > r_count) begin
                    n_status = ST_RANGE;
                end else if (r_count == CW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                end
                n_ptr = w_cnt_m1[AW-1:0];
            end
            KIND_REMOVE: begin
                n_status = (i_position >= r_count) ? ST_RANGE : ST_DONE;
                n_ptr    = w_in_pos_p1[AW-1:0];
            end
            KIND_READ: begin
                n_status = (i_position >= r_count) ? ST_RANGE : ST_DONE;
                n_ptr    = i_position[AW-1:0];
            end
            default: begin
                n_status = ST_DONE;
                n_ptr    = i_position[AW-1:0];
            end
        endcase
    end

    always_comb begin
        o_stat.kind = r_kind;
        o_stat.ok   = (r_status == ST_DONE);
        if (r_kind == KIND_INSERT) begin
            o_stat.need_shift = (r_pos != r_count);
            o_stat.ptr_last   = (r_ptr == r_pos[AW-1:0]);
        end else begin
            o_stat.need_shift = (w_pos_p1 != r_count);
            o_stat.ptr_last   = (r_ptr == w_cnt_m1[AW-1:0]);
        end
    end

    always_comb begin
        w_we = r_prev_vld | i_cmd.put_value;
        if (r_prev_vld) begin
            w_waddr = (r_kind == KIND_INSERT) ? r_prev_addr + AW'(1) : r_prev_addr - AW'(1);
            w_wdata = w_rdata;
        end else begin
            w_waddr = r_pos[AW-1:0];
            w_wdata = r_value;
        end
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = w_cnt_m1;
        end
    end

    iole_ram #(
        .W(WIDTH),
        .D(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_prev_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_prev_vld <= i_cmd.rd_issue && (r_kind != KIND_READ);
            r_valid    <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_pos    <= i_position;
            r_value  <= i_value;
            r_status <= n_status;
            r_ptr    <= n_ptr;
        end else if (i_cmd.rd_issue) begin
            r_ptr <= (r_kind == KIND_INSERT) ? r_ptr - AW'(1) : r_ptr + AW'(1);
        end
        if (i_cmd.rd_issue) begin
            r_prev_addr <= r_ptr;
        end
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_word   <= (r_kind == KIND_READ && r_status == ST_DONE) ? w_rdata : '0;
            r_out_count  <= n_count;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_word;
    assign o_count      = r_out_count;

endmodule
`default_nettype wire

// ===== hw/rtl/iole_ctrl.sv =====
// Controller state machine that sequences each list request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module iole_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire iole_pkg::t_stat i_stat,
    output iole_pkg::t_cmd       o_cmd
);
    import iole_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHIFT,
        S_FLUSH,
        S_PUT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    case (i_stat.kind)
                        KIND_INSERT: begin
                            n_state = i_stat.need_shift ? S_SHIFT : S_PUT;
                        end
                        KIND_REMOVE: begin
                            if (i_stat.need_shift) begin
                                n_state = S_SHIFT;
                            end else begin
                                o_cmd.finish  = 1'b1;
                                o_cmd.cnt_dec = 1'b1;
                                n_state       = S_IDLE;
                            end
                        end
                        KIND_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_FIN;
                        end
                        default: begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_cmd.rd_issue = 1'b1;
                if (i_stat.ptr_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.kind == KIND_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_PUT: begin
                o_cmd.put_value = 1'b1;
                o_cmd.finish    = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                n_state         = S_IDLE;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_ordered_list_engine.sv =====
// Top level of the indexed ordered list engine.
//
// A request word (i_kind, i_position, i_value) is taken when start is high
// and busy is low. Kind 0 inserts i_value at a position from 0 to the count,
// kind 1 removes the word at a position below the count, kind 2 reads it.
// Each request gives one result word on o_status, o_read_value and o_count,
// shown for a single cycle with o_valid high; the receiver cannot stall it.
// Words are kept in one RAM with one write and one registered read port, and
// the later entries are moved one at a time through that port pair.
// With n entries and position p, the states run: insert dispatch, shift, flush,
// put (dispatch, put if p = n); remove dispatch, shift, flush (dispatch if p
// = n-1); read dispatch, fin; a request out of range or full, dispatch alone.
// A new request may be taken in the cycle that o_valid is high.
// Reset clears the count and the controller; the RAM contents are not cleared
// and are only read at positions that were written since.
`timescale 1ns / 1ps
`default_nettype none
module indexed_ordered_list_engine #(
    parameter int DEPTH = iole_pkg::DEPTH_DEF,
    parameter int WIDTH = iole_pkg::WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_position,
    input  wire logic [WIDTH-1:0]           i_value,
    output logic                            o_valid,
    output logic      [1:0]                 o_status,
    output logic      [WIDTH-1:0]           o_read_value,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    import iole_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    iole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    iole_datapath #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/iole_checker.sv =====
// Port-level checker for the indexed ordered list engine, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_ordered_list_engine_assert.svh"
module iole_checker #(
    parameter int DEPTH = iole_pkg::DEPTH_DEF,
    parameter int WIDTH = iole_pkg::WIDTH_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire logic [1:0]                 o_status,
    input wire logic [WIDTH-1:0]           o_read_value,
    input wire logic [$clog2(DEPTH+1)-1:0] o_count
);
    import iole_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    `IOLE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `IOLE_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `IOLE_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_valid, o_count <= CW'(DEPTH))
    `IOLE_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_count == CW'(DEPTH))
    `IOLE_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != ST_DONE, o_read_value == '0)

endmodule

bind indexed_ordered_list_engine iole_checker #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
) u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_read_value (o_read_value),
    .o_count      (o_count)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the indexed ordered list engine, with a queue-based scoreboard.
`timescale 1ns / 1ps
module testbench;
    import iole_pkg::*;

    localparam int DEPTH = iole_pkg::DEPTH_DEF;
    localparam int WIDTH = iole_pkg::WIDTH_DEF;
    localparam int POS_W = $clog2(DEPTH + 1);
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int BLOCKS = 8;
    localparam int BLOCK_ITEMS = 200;

    typedef struct {
        logic [1:0]       status;
        logic [WIDTH-1:0] read_value;
        logic [POS_W-1:0] count;
    } t_outcome;

    class list_scoreboard;
        logic [WIDTH-1:0] stored_words[$];
        t_outcome         awaited[$];
        int errors;
        int compared;
        int range_flags;
        int full_flags;

        function int stored();
            return stored_words.size();
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void note_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                                   logic [WIDTH-1:0] word);
            t_outcome want;
            int p;
            int n;
            p = int'(pos);
            n = stored_words.size();
            want.status = ST_DONE;
            want.read_value = '0;
            case (kind)
                KIND_INSERT: begin
                    if (p > n) begin
                        want.status = ST_RANGE;
                    end else if (n >= DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        stored_words.insert(p, word);
                    end
                end
                KIND_REMOVE: begin
                    if (p >= n) begin
                        want.status = ST_RANGE;
                    end else begin
                        stored_words.delete(p);
                    end
                end
                KIND_READ: begin
                    if (p >= n) begin
                        want.status = ST_RANGE;
                    end else begin
                        want.read_value = stored_words[p];
                    end
                end
                default: begin
                end
            endcase
            want.count = POS_W'(stored_words.size());
            if (want.status == ST_RANGE) begin
                range_flags++;
            end
            if (want.status == ST_FULL) begin
                full_flags++;
            end
            awaited.push_back(want);
        endfunction

        function void check_result(logic [1:0] status, logic [WIDTH-1:0] rd,
                                   logic [POS_W-1:0] cnt);
            t_outcome want;
            if (awaited.size() == 0) begin
                $error("result word arrived with no request outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            compared++;
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (rd !== want.read_value) begin
                $error("read_value: expected %h, got %h", want.read_value, rd);
                errors++;
            end
            if (cnt !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_kind = KIND_READ;
    logic [POS_W-1:0] i_position = '0;
    logic [WIDTH-1:0] i_value = '0;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [WIDTH-1:0] o_read_value;
    logic [POS_W-1:0] o_count;

    list_scoreboard sb = new;
    int issued = 0;
    int cycles = 0;

    indexed_ordered_list_engine #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_read_value(o_read_value),
        .o_count(o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result(o_status, o_read_value, o_count);
        end
    end

    task automatic send(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                        input logic [WIDTH-1:0] word);
        start      <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= word;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_request(kind, pos, word);
        issued++;
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (sb.outstanding() != 0) begin
            start <= 1'b0;
            while (sb.outstanding() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        int blk;
        int item;
        int burst;
        int n;
        int r;
        int lim;
        logic [1:0] k;
        logic [POS_W-1:0] p;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(KIND_READ, 0, 32'h1234_5678);
        send(KIND_REMOVE, 0, 32'h0);
        send(KIND_INSERT, 1, 32'hDEAD_BEEF);
        send(KIND_INSERT, 0, 32'h0000_0000);
        send(KIND_INSERT, 1, 32'hFFFF_FFFF);
        send(KIND_INSERT, 0, 32'hA5A5_A5A5);
        send(KIND_INSERT, 1, 32'h5A5A_5A5A);
        send(KIND_READ, 0, 32'h0);
        send(KIND_READ, 3, 32'h0);
        send(KIND_READ, 4, 32'h0);
        send(KIND_READ, 127, 32'hFFFF_FFFF);
        send(KIND_INSERT, 127, $urandom);
        send(KIND_INSERT, 5, $urandom);
        send(KIND_REMOVE, 3, 32'h0);
        send(KIND_REMOVE, 0, 32'h0);
        send(KIND_SPARE, 127, 32'hFFFF_FFFF);
        send(KIND_SPARE, 0, 32'h0);
        send(KIND_REMOVE, 2, 32'h0);
        send(KIND_READ, 1, 32'h0);
        send(KIND_REMOVE, 1, 32'h0);
        send(KIND_REMOVE, 0, 32'h0);
        send(KIND_REMOVE, 0, 32'h0);
        drain();

        // Blocks alternate between filling, emptying and a balanced mix, so that
        // both the full and the empty list are reached several times over.
        for (blk = 0; blk < BLOCKS; blk++) begin
            burst = $urandom_range(1, 40);
            for (item = 0; item < BLOCK_ITEMS; item++) begin
                if (burst == 0) begin
                    pause($urandom_range(1, 6));
                    burst = $urandom_range(1, 40);
                end
                burst--;
                r = $urandom_range(0, 99);
                case (blk % 3)
                    0: k = (r < 65) ? KIND_INSERT : (r < 80) ? KIND_REMOVE :
                           (r < 96) ? KIND_READ : KIND_SPARE;
                    1: k = (r < 15) ? KIND_INSERT : (r < 75) ? KIND_REMOVE :
                           (r < 96) ? KIND_READ : KIND_SPARE;
                    default: k = (r < 40) ? KIND_INSERT : (r < 70) ? KIND_REMOVE :
                                 (r < 96) ? KIND_READ : KIND_SPARE;
                endcase
                n = sb.stored();
                lim = (k == KIND_INSERT) ? n + 1 : n;
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    p = POS_W'($urandom_range(lim, 127));
                end else if (r < 25) begin
                    p = '0;
                end else if (r < 40) begin
                    p = (lim > 0) ? POS_W'(lim - 1) : '0;
                end else begin
                    p = (lim > 0) ? POS_W'($urandom_range(0, lim - 1)) : '0;
                end
                send(k, p, $urandom);
            end
            drain();
        end

        drain();
        pause(80);
        $display("summary: %0d requests issued, %0d result words compared",
                 issued, sb.compared);
        $display("summary: %0d out-of-range flags and %0d full-list flags predicted",
                 sb.range_flags, sb.full_flags);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== indexed_ordered_list_engine.f =====
+incdir+hw/rtl
hw/rtl/iole_pkg.sv
hw/rtl/iole_ram.sv
hw/rtl/iole_datapath.sv
hw/rtl/iole_ctrl.sv
hw/rtl/indexed_ordered_list_engine.sv
hw/rtl/iole_checker.sv
tb/testbench.sv
